@@ rtl/sha256_pkg.sv @@
package sha256_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic        start_message;
        logic        final_block;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_word;
    } out_item_t;

    // One complete block handed from the front to the back.
    typedef struct packed {
        logic [15:0][31:0] words;
        logic              restart;
        logic              final_flag;
    } blk_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } core_state_t;

    localparam logic [7:0][31:0] INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ rtl/sha256_front.sv @@
module sha256_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sha256_pkg::in_item_t in_data,
    output logic                 blk_valid,
    input  logic                 blk_ready,
    output sha256_pkg::blk_t     blk_data
);
    import sha256_pkg::*;

    logic [15:0][31:0] win_reg;
    logic [3:0]        count_reg;
    logic              restart_reg;
    logic              final_reg;
    logic              full_reg;
    logic [3:0]        slot;
    logic              take;

    // Stall every input word while a completed block waits in the hand-off slot.
    assign take     = in_valid && in_ready;
    assign in_ready = !full_reg;
    assign slot     = in_data.start_message ? 4'd0 : count_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            win_reg[slot] <= in_data.message_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            restart_reg <= 1'b0;
            final_reg   <= 1'b0;
            full_reg    <= 1'b0;
        end
        else
        begin
            if (full_reg && blk_ready)
            begin
                full_reg    <= 1'b0;
                restart_reg <= 1'b0;
                final_reg   <= 1'b0;
            end
            if (take)
            begin
                count_reg <= slot + 4'd1;
                if (in_data.start_message)
                begin
                    restart_reg <= 1'b1;
                    final_reg   <= in_data.final_block;
                end
                else
                begin
                    final_reg <= final_reg | in_data.final_block;
                end
                if (slot == 4'd15)
                begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

    assign blk_valid           = full_reg;
    assign blk_data.words      = win_reg;
    assign blk_data.restart    = restart_reg;
    assign blk_data.final_flag = final_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        take && slot == 4'd15 |=> blk_valid)
        else $error("completed block not handed off");
    assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !blk_ready |=> $stable(win_reg))
        else $error("window changed while held");
    assert property (@(posedge clk) disable iff (!rst_n)
        take && slot != 4'd15 |=> count_reg == $past(slot) + 4'd1)
        else $error("word count slip");
endmodule

@@ rtl/sha256_core.sv @@
module sha256_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  blk_valid,
    output logic                  blk_ready,
    input  sha256_pkg::blk_t      blk_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_item_t out_data
);
    import sha256_pkg::*;

    core_state_t       state_reg, state_next;
    logic [7:0][31:0]  chain_reg;
    logic [7:0][31:0]  v_reg;
    logic [15:0][31:0] w_reg;
    logic [5:0]        rnd_reg;
    logic [2:0]        idx_reg;
    logic              final_reg;
    logic [7:0][31:0]  base;
    logic [31:0]       s0, s1, wnew, t1, t2, ch, maj;
    logic              load;

    // Take a block only when idle; restart uses the initial hash as base.
    assign blk_ready = (state_reg == ST_IDLE);
    assign load      = blk_valid && blk_ready;
    assign base      = blk_data.restart ? INIT_HASH : chain_reg;

    assign s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign wnew = w_reg[0] + s0 + w_reg[9] + s1;
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1   = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
                + ch + round_k(rnd_reg) + w_reg[0];
    assign t2   = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22)) + maj;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (load) state_next = ST_ROUND;
            ST_ROUND: if (rnd_reg == 6'd63) state_next = ST_ADD;
            ST_ADD:   state_next = final_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (out_ready && idx_reg == 3'd7) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid             = (state_reg == ST_EMIT);
        out_data.digest_word  = chain_reg[idx_reg];
        out_data.digest_index = idx_reg;
        out_data.last_word    = (idx_reg == 3'd7);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            w_reg <= blk_data.words;
            v_reg <= base;
        end
        else if (state_reg == ST_ROUND)
        begin
            w_reg <= {wnew, w_reg[15:1]};
            v_reg <= {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= INIT_HASH;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                chain_reg <= base;
                final_reg <= blk_data.final_flag;
                rnd_reg   <= '0;
                idx_reg   <= '0;
            end
            if (state_reg == ST_ROUND)
            begin
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
            end
            if (state_reg == ST_EMIT && out_ready)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND && rnd_reg == 6'd63 |=> state_reg == ST_ADD)
        else $error("round count overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(chain_reg) && $stable(idx_reg))
        else $error("digest changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADD && !final_reg |=> state_reg == ST_IDLE)
        else $error("non-final block emitted");
endmodule

@@ rtl/sha256_compression_engine.sv @@
// SHA-256 compression engine.
// Input channel (in_valid/in_ready/in_data): padded message words, sixteen
// per 512-bit block, most significant word first. start_message on a word
// drops any partial block and reloads the initial hash; final_block on any
// word of a block marks that block as the message's last.
// Output channel (out_valid/out_ready/out_data): after a final block, eight
// digest words, index 0 first, last_word set on index 7.
// Structure: a front collects one block in a window that doubles as a
// one-deep hand-off slot; the back runs one round per cycle. The front keeps
// taking all sixteen words of the next block while the back works.
// Each block passes through a load, 64 rounds and one add in the back end,
// whose single round unit sets the sustained rate.
// After the back end takes a final block and runs its rounds and add, the
// digest follows, one word per cycle while out_ready is high. A stalled
// receiver holds the back end; the front then fills its hand-off slot with
// the next block and stalls at the first word after it.
// Reset puts the chain at the initial hash values and empties both parts.
module sha256_compression_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_item_t out_data
);
    import sha256_pkg::*;

    logic blk_valid;
    logic blk_ready;
    blk_t blk_data;

    sha256_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data)
    );

    sha256_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_data  (blk_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("digest transfer dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> !out_valid)
        else $error("extra digest word");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !blk_ready)
        else $error("block taken during digest");
endmodule
